>>> src/crfab_pkg.sv
// ----------------------------------------------------------------------------
// crfab_pkg: shared types and constants of the blitter
// operation codes, item structs and the blend helper
// ----------------------------------------------------------------------------
package crfab_pkg;

	typedef enum logic [2:0] {
		OP_FILL       = 3'd0,
		OP_ERASE_RECT = 3'd1,
		OP_ERASE_ALL  = 3'd2,
		OP_BLIT_START = 3'd3,
		OP_BLIT_PIXEL = 3'd4,
		OP_READ       = 3'd5
	} op_t;

	localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd0;
	localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BACKGROUND    = 2'd2;

	localparam int CfgDataWidth = 24;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        width;
		logic [15:0]        height;
		logic [23:0]        color;
		logic [7:0]         alpha;
	} in_item_t;

	typedef struct packed {
		logic [23:0] pixel_color;
		logic        in_window;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAINT
	} state_t;

	// (v + 127) / 255 for v up to 255 * 255, by reciprocal: (t + (t >> 8) + 1) >> 8 with t = v + 127
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		logic [17:0] u;
		begin
			t = {1'b0, v} + 17'd127;
			u = {1'b0, t} + {9'd0, t[16:8]} + 18'd1;
			div255 = u[15:8];
		end
	endfunction

endpackage

>>> src/crfab_blend.sv
// ----------------------------------------------------------------------------
// crfab_blend: per-channel alpha blend
// mul255(src, a) + mul255(dst, 255 - a) on three channels
// ----------------------------------------------------------------------------
module crfab_blend (
	input  logic [23:0] src,
	input  logic [23:0] dst,
	input  logic [7:0]  alpha,
	output logic [23:0] res
);

	logic [7:0] na;
	assign na = 8'd255 - alpha;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			res[c*8 +: 8] = crfab_pkg::div255(16'(src[c*8 +: 8] * alpha))
				+ crfab_pkg::div255(16'(dst[c*8 +: 8] * na));
		end
	end

endmodule

>>> src/clipped_rect_fill_alpha_blitter_unit.sv
// ----------------------------------------------------------------------------
// clipped_rect_fill_alpha_blitter_unit: 2d blitter with clipping and alpha blend
// frame store fill, erase, blended blit and pixel read
// ----------------------------------------------------------------------------
// Fills and erases write one covered pixel per cycle, and no item is accepted
// meanwhile. The frame store is a synchronous memory with one read port and
// one write port: a blit pixel inside the window is read one cycle and written
// back the next, and no item is accepted until the write-back; a blit pixel
// outside the window or past the picture is passed over without a write. A read
// result sits in an output register and no item is accepted until it is taken.
// Blit start and ignored items do not hold up the next item. The store needs no
// clearing after reset.
module clipped_rect_fill_alpha_blitter_unit #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  crfab_pkg::in_item_t     in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output crfab_pkg::out_item_t    out_data,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [crfab_pkg::CfgDataWidth-1:0] cfg_data
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DEPTH = 1 << AW;

	logic [9:0]  win_w_q, win_h_q;
	logic [23:0] bg_q;
	logic signed [15:0] org_x_q, org_y_q;
	logic [15:0] size_w_q, size_h_q, col_q, row_q;

	logic [23:0] mem [DEPTH];
	logic [23:0] rd_data;

	crfab_pkg::state_t state_q, state_d;

	// effective window, 13 bits enough for 4096
	logic [12:0] ew, eh;
	assign ew = ({3'd0, win_w_q} < 13'(MAX_WIDTH)) ? {3'd0, win_w_q} : 13'(MAX_WIDTH);
	assign eh = ({3'd0, win_h_q} < 13'(MAX_HEIGHT)) ? {3'd0, win_h_q} : 13'(MAX_HEIGHT);

	function automatic logic [12:0] clampv(input logic signed [17:0] v, input logic [12:0] hi);
		if (v < 0) clampv = 13'd0;
		else if (v > $signed({5'd0, hi})) clampv = hi;
		else clampv = v[12:0];
	endfunction

	// paint sweep
	logic [12:0] px_q, x0_q, x1_q, py_q, y1_q;
	logic [23:0] pcol_q;

	// registered stage after acceptance, for blend and read
	logic        blend_s1, read_s1;
	logic [AW-1:0] addr_s1;
	logic [23:0] src_s1;
	logic [7:0]  a_s1;
	logic        inwin_s1;

	logic [23:0] blend_res;
	crfab_blend u_blend (.src(src_s1), .dst(rd_data), .alpha(a_s1), .res(blend_res));

	logic acc;
	assign in_ready = (state_q == crfab_pkg::ST_IDLE) && !blend_s1 && !read_s1 && !out_valid;
	assign acc = in_valid && in_ready;

	// decode of accepted item
	logic signed [17:0] sx, sy, ex, ey;
	logic [12:0] cx0, cx1, cy0, cy1;
	logic signed [17:0] bx, by;
	logic b_live, b_in, r_in;
	assign sx = 18'(in_data.x);
	assign sy = 18'(in_data.y);
	assign ex = sx + $signed({2'd0, in_data.width});
	assign ey = sy + $signed({2'd0, in_data.height});
	assign cx0 = clampv(sx, ew);
	assign cx1 = clampv(ex, ew);
	assign cy0 = clampv(sy, eh);
	assign cy1 = clampv(ey, eh);
	assign bx = 18'(org_x_q) + $signed({2'd0, col_q});
	assign by = 18'(org_y_q) + $signed({2'd0, row_q});
	assign b_live = (size_w_q != 16'd0) && (row_q < size_h_q);
	assign b_in = bx >= 0 && by >= 0 && bx < $signed({5'd0, ew}) && by < $signed({5'd0, eh});
	assign r_in = sx >= 0 && sy >= 0 && sx < $signed({5'd0, ew}) && sy < $signed({5'd0, eh});

	logic op_paint;
	logic [2:0] op;
	assign op = in_data.operation;
	assign op_paint = acc && (op == crfab_pkg::OP_FILL || op == crfab_pkg::OP_ERASE_RECT
		|| op == crfab_pkg::OP_ERASE_ALL);

	// paint start values
	logic [12:0] nx0, nx1, ny0, ny1;
	always_comb begin
		if (op == crfab_pkg::OP_ERASE_ALL) begin
			nx0 = 13'd0; nx1 = ew; ny0 = 13'd0; ny1 = eh;
		end else begin
			nx0 = cx0; nx1 = cx1; ny0 = cy0; ny1 = cy1;
		end
	end

	logic paint_done;
	assign paint_done = (x0_q >= x1_q) || (py_q >= y1_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crfab_pkg::ST_IDLE: if (op_paint) state_d = crfab_pkg::ST_PAINT;
			crfab_pkg::ST_PAINT: begin
				if (paint_done || (px_q + 13'd1 >= x1_q && py_q + 13'd1 >= y1_q))
					state_d = crfab_pkg::ST_IDLE;
			end
			default: state_d = crfab_pkg::ST_IDLE;
		endcase
	end

	// memory port
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [23:0]   mem_wd;
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_s1;
		mem_wd = blend_res;
		if (blend_s1) begin
			mem_we = 1'b1;
		end else if (state_q == crfab_pkg::ST_PAINT && !paint_done) begin
			mem_we = 1'b1;
			mem_wa = {py_q[YW-1:0], px_q[XW-1:0]};
			mem_wd = pcol_q;
		end
		if (op == crfab_pkg::OP_READ) mem_ra = {sy[YW-1:0], sx[XW-1:0]};
		else mem_ra = {by[YW-1:0], bx[XW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_data <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		addr_s1 <= mem_ra;
		src_s1 <= in_data.color;
		a_s1 <= in_data.alpha;
		inwin_s1 <= r_in;
		if (op_paint) begin
			x0_q <= nx0; x1_q <= nx1; px_q <= nx0; py_q <= ny0; y1_q <= ny1;
			pcol_q <= (op == crfab_pkg::OP_FILL) ? in_data.color : bg_q;
		end else if (state_q == crfab_pkg::ST_PAINT) begin
			if (px_q + 13'd1 >= x1_q) begin
				px_q <= x0_q;
				py_q <= py_q + 13'd1;
			end else begin
				px_q <= px_q + 13'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crfab_pkg::ST_IDLE;
			win_w_q <= '0; win_h_q <= '0; bg_q <= '0;
			org_x_q <= '0; org_y_q <= '0; size_w_q <= '0; size_h_q <= '0;
			col_q <= '0; row_q <= '0;
			blend_s1 <= 1'b0; read_s1 <= 1'b0;
			out_valid <= 1'b0; out_data <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					crfab_pkg::REG_WINDOW_WIDTH:  win_w_q <= cfg_data[9:0];
					crfab_pkg::REG_WINDOW_HEIGHT: win_h_q <= cfg_data[9:0];
					crfab_pkg::REG_BACKGROUND:    bg_q <= cfg_data;
					default: ;
				endcase
			end
			blend_s1 <= acc && op == crfab_pkg::OP_BLIT_PIXEL && b_live && b_in;
			read_s1 <= acc && op == crfab_pkg::OP_READ;
			if (acc && op == crfab_pkg::OP_BLIT_START) begin
				org_x_q <= in_data.x; org_y_q <= in_data.y;
				size_w_q <= in_data.width; size_h_q <= in_data.height;
				col_q <= '0; row_q <= '0;
			end
			if (acc && op == crfab_pkg::OP_BLIT_PIXEL && b_live) begin
				if (col_q + 16'd1 >= size_w_q) begin
					col_q <= '0;
					row_q <= row_q + 16'd1;
				end else begin
					col_q <= col_q + 16'd1;
				end
			end
			if (read_s1) begin
				out_valid <= 1'b1;
				out_data.in_window <= inwin_s1;
				out_data.pixel_color <= inwin_s1 ? rd_data : 24'd0;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

>>> src/crfab_checker.sv
// ----------------------------------------------------------------------------
// crfab_checker: port-level checks of the blitter
// handshake and result sanity seen from the ports
// ----------------------------------------------------------------------------
module crfab_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input crfab_pkg::out_item_t out_data
);

	// a pending result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// out of window reads return zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.in_window |-> out_data.pixel_color == 24'd0)
		else $error("outside read not zero");

	// no new item taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken with result pending");

	// a result appears only for an accepted item, through the read stage register and then the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("spurious result");

endmodule

bind clipped_rect_fill_alpha_blitter_unit crfab_checker u_crfab_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
